// ===== rtl/aerm_pkg.sv =====
// aerm_pkg: shared types, codes, counts and AES byte functions for the AES round MAC engine
// no dependencies; used by every module in rtl/
package aerm_pkg;

	typedef logic [127:0] blk_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_KEXP,
		S_DENC,
		S_ABS,
		S_ZABS,
		S_NENC,
		S_MOD,
		S_MERGE,
		S_TENC,
		S_HOLD
	} state_t;

	typedef enum logic [1:0] {
		TGT_MASTER,
		TGT_NONCE,
		TGT_TAG
	} tgt_t;

	localparam logic [1:0] ACT_ABSORB  = 2'd0;
	localparam logic [1:0] ACT_FINAL   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic CFG_KEY_LO = 1'b0;
	localparam logic CFG_KEY_HI = 1'b1;

	localparam int NUM_CHAIN   = 9;
	localparam int NUM_MIX     = 4;
	localparam int NUM_SUBKEY  = 18;
	localparam int NUM_RK      = 11;
	localparam int LAST_ROUND  = 10;
	localparam int KEXP_LAST   = 10;
	localparam int ZABS_LAST   = 3;
	localparam int MOD_ROUNDS  = 10;
	localparam int MOD_LAST    = 17;
	localparam int NUM_ICV     = 9;
	localparam int CTR_NONCE   = 27;
	localparam int CTR_TAG     = 28;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] xtime(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k of a block sits in bits 8k+7:8k, row k%4 of column k/4
	function automatic blk_t sub_shift(blk_t x);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[8*(4*c+r) +: 8] = SBOX[x[8*(4*((c+r)%4)+r) +: 8]];
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_cols(blk_t x);
		blk_t t;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			a0 = x[32*c +: 8];
			a1 = x[32*c+8 +: 8];
			a2 = x[32*c+16 +: 8];
			a3 = x[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
			t[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
			t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [7:0] rcon(logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// next AES-128 round key from the previous one
	function automatic blk_t key_step(blk_t k, logic [7:0] rc);
		logic [31:0] t, n0, n1, n2, n3;
		t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
		n0 = k[31:0] ^ t;
		n1 = k[63:32] ^ n0;
		n2 = k[95:64] ^ n1;
		n3 = k[127:96] ^ n2;
		return {n3, n2, n1, n0};
	endfunction

endpackage

// ===== rtl/aerm_lane.sv =====
// aerm_lane: one AES round lane, SubBytes, ShiftRows, optional MixColumns, key add
// depends on aerm_pkg
module aerm_lane (
	input  aerm_pkg::blk_t din,
	input  aerm_pkg::blk_t rkey,
	input  logic           mix_en,
	output aerm_pkg::blk_t dout
);

	aerm_pkg::blk_t ss;

	assign ss   = aerm_pkg::sub_shift(din);
	assign dout = (mix_en ? aerm_pkg::mix_cols(ss) : ss) ^ rkey;

endmodule

// ===== rtl/aerm_merge.sv =====
// aerm_merge: registered xor merge of the nine lane results, the nonce cipher and the nonce
// depends on aerm_pkg
module aerm_merge (
	input  logic           clk,
	input  logic           en,
	input  aerm_pkg::blk_t lane_res [aerm_pkg::NUM_CHAIN],
	input  aerm_pkg::blk_t enc_res,
	input  aerm_pkg::blk_t nonce,
	output aerm_pkg::blk_t acc
);

	aerm_pkg::blk_t sum;
	aerm_pkg::blk_t acc_q;

	always_comb begin
		sum = enc_res ^ nonce;
		for (int i = 0; i < aerm_pkg::NUM_CHAIN; i++) begin
			sum = sum ^ lane_res[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= sum;
		end
	end

	assign acc = acc_q;

endmodule

// ===== rtl/aes_round_mac_engine_unit.sv =====
// aes_round_mac_engine_unit: top level of the AES round keyed MAC engine
// depends on aerm_pkg, aerm_lane, aerm_merge
//
// A full 64-byte block (absorb) or a restart request is registered first; then eight AES
// round lanes and an xor update all chain words in one pass, or a restart reloads them
// from the derived chain values. A finalize request runs a tail absorb, four zero-block
// absorbs, a nonce encryption on lane 0, 10 rounds on all nine lanes while the subkey
// ring turns back in place, a merge, a tag encryption and the load of the output
// register. Writing a key register starts key derivation (three key expansions and 29
// encryptions on lane 0); in_ready stays low until it is done. One request is in work
// at a time; a finished tag waits in the output register while the next request is
// taken.
module aes_round_mac_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] msg_word0,
	input  logic [63:0] msg_word1,
	input  logic [63:0] msg_word2,
	input  logic [63:0] msg_word3,
	input  logic [63:0] msg_word4,
	input  logic [63:0] msg_word5,
	input  logic [63:0] msg_word6,
	input  logic [63:0] msg_word7,
	input  logic [5:0]  byte_count,
	input  logic [63:0] nonce_lo,
	input  logic [63:0] nonce_hi,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] tag_lo,
	output logic [63:0] tag_hi
);

	localparam int NC = aerm_pkg::NUM_CHAIN;

	aerm_pkg::state_t state_q, state_d;
	aerm_pkg::tgt_t   tgt_q;
	logic [4:0]       cnt_q;
	logic [3:0]       rnd_q;
	logic [4:0]       ctr_q;
	logic [1:0]       act_q;
	logic             out_valid_q;
	logic [127:0]     key_q;

	aerm_pkg::blk_t chain_q [NC];
	aerm_pkg::blk_t mix_q [aerm_pkg::NUM_MIX];
	aerm_pkg::blk_t icv_q [aerm_pkg::NUM_ICV];
	aerm_pkg::blk_t fsk_q [aerm_pkg::NUM_SUBKEY];
	aerm_pkg::blk_t mk_q [aerm_pkg::NUM_RK];
	aerm_pkg::blk_t nk_q [aerm_pkg::NUM_RK];
	aerm_pkg::blk_t tk_q [aerm_pkg::NUM_RK];
	aerm_pkg::blk_t wk_q [NC];
	aerm_pkg::blk_t enc_q, kx_q, nonce_q, tag_q;
	logic [511:0]   blk_q;

	logic [511:0]   raw_blk, pad_blk;
	aerm_pkg::blk_t lane_d [NC];
	aerm_pkg::blk_t lane_k [NC];
	aerm_pkg::blk_t lane_o [NC];
	logic           lane_mix;
	aerm_pkg::blk_t m0, m1, m2, m3, r12;
	aerm_pkg::blk_t enc_key, enc_src, acc;
	logic           in_acc, enc_st, enc_done, absorb_en, hold_load, merge_en, kexp_last;

	// ---------------- request capture with tail padding ----------------
	assign raw_blk = {msg_word7, msg_word6, msg_word5, msg_word4,
	                  msg_word3, msg_word2, msg_word1, msg_word0};

	always_comb begin
		pad_blk = raw_blk;
		if (action == aerm_pkg::ACT_FINAL) begin
			for (int k = 0; k < 64; k++) begin
				if (6'(k) == byte_count) begin
					pad_blk[8*k +: 8] = 8'h01;
				end else if (6'(k) > byte_count) begin
					pad_blk[8*k +: 8] = 8'h00;
				end
			end
		end
	end

	// ---------------- control decode ----------------
	always_comb begin
		in_ready  = (state_q == aerm_pkg::S_IDLE) && !cfg_we;
		in_acc    = in_valid && in_ready;
		enc_st    = (state_q == aerm_pkg::S_DENC) || (state_q == aerm_pkg::S_NENC) ||
		            (state_q == aerm_pkg::S_TENC);
		enc_done  = enc_st && (rnd_q == 4'(aerm_pkg::LAST_ROUND));
		absorb_en = (state_q == aerm_pkg::S_ZABS) ||
		            ((state_q == aerm_pkg::S_ABS) &&
		             ((act_q == aerm_pkg::ACT_ABSORB) || (act_q == aerm_pkg::ACT_FINAL)));
		hold_load = (state_q == aerm_pkg::S_HOLD) && (!out_valid_q || out_ready);
		merge_en  = (state_q == aerm_pkg::S_MERGE);
		kexp_last = (state_q == aerm_pkg::S_KEXP) && (cnt_q == 5'(aerm_pkg::KEXP_LAST));
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = aerm_pkg::S_KEXP;
		end else begin
			unique case (state_q)
				aerm_pkg::S_IDLE: begin
					if (in_acc) state_d = aerm_pkg::S_ABS;
				end
				aerm_pkg::S_KEXP: begin
					if (kexp_last) begin
						state_d = (tgt_q == aerm_pkg::TGT_TAG) ? aerm_pkg::S_IDLE
						                                       : aerm_pkg::S_DENC;
					end
				end
				aerm_pkg::S_DENC: begin
					if (enc_done && (ctr_q == 5'(aerm_pkg::CTR_NONCE) ||
					                 ctr_q == 5'(aerm_pkg::CTR_TAG))) begin
						state_d = aerm_pkg::S_KEXP;
					end
				end
				aerm_pkg::S_ABS: begin
					state_d = (act_q == aerm_pkg::ACT_FINAL) ? aerm_pkg::S_ZABS
					                                         : aerm_pkg::S_IDLE;
				end
				aerm_pkg::S_ZABS: begin
					if (cnt_q == 5'(aerm_pkg::ZABS_LAST)) state_d = aerm_pkg::S_NENC;
				end
				aerm_pkg::S_NENC: begin
					if (enc_done) state_d = aerm_pkg::S_MOD;
				end
				aerm_pkg::S_MOD: begin
					if (cnt_q == 5'(aerm_pkg::MOD_LAST)) state_d = aerm_pkg::S_MERGE;
				end
				aerm_pkg::S_MERGE: state_d = aerm_pkg::S_TENC;
				aerm_pkg::S_TENC: begin
					if (enc_done) state_d = aerm_pkg::S_HOLD;
				end
				aerm_pkg::S_HOLD: begin
					if (hold_load) state_d = aerm_pkg::S_IDLE;
				end
				default: state_d = aerm_pkg::S_IDLE;
			endcase
		end
	end

	// ---------------- lane operand selection ----------------
	assign m0  = (state_q == aerm_pkg::S_ZABS) ? '0 : blk_q[127:0];
	assign m1  = (state_q == aerm_pkg::S_ZABS) ? '0 : blk_q[255:128];
	assign m2  = (state_q == aerm_pkg::S_ZABS) ? '0 : blk_q[383:256];
	assign m3  = (state_q == aerm_pkg::S_ZABS) ? '0 : blk_q[511:384];
	assign r12 = mix_q[1] ^ mix_q[2];

	always_comb begin
		unique case (state_q)
			aerm_pkg::S_NENC: begin
				enc_key = nk_q[0];
				enc_src = nonce_q;
			end
			aerm_pkg::S_TENC: begin
				enc_key = tk_q[0];
				enc_src = acc;
			end
			default: begin
				enc_key = mk_q[0];
				enc_src = {123'd0, ctr_q};
			end
		endcase
	end

	always_comb begin
		lane_mix = 1'b1;
		for (int i = 0; i < NC; i++) begin
			lane_d[i] = '0;
			lane_k[i] = '0;
		end
		if (absorb_en) begin
			for (int i = 0; i < NC - 1; i++) begin
				lane_d[i] = chain_q[i];
			end
			lane_k[0] = m3;
			lane_k[1] = m3;
			lane_k[2] = r12;
			lane_k[3] = m0;
			lane_k[4] = m0;
			lane_k[5] = m1;
			lane_k[6] = m1;
			lane_k[7] = m3;
		end else if (enc_st) begin
			lane_d[0] = enc_q;
			lane_k[0] = enc_key;
			lane_mix  = (rnd_q != 4'(aerm_pkg::LAST_ROUND));
		end else if (state_q == aerm_pkg::S_MOD) begin
			for (int i = 0; i < NC; i++) begin
				lane_d[i] = ((cnt_q == 5'd0) ? chain_q[i] : wk_q[i]) ^ fsk_q[i];
			end
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_lane
		aerm_lane u_lane (
			.din   (lane_d[g]),
			.rkey  (lane_k[g]),
			.mix_en(lane_mix),
			.dout  (lane_o[g])
		);
	end

	aerm_merge u_merge (
		.clk     (clk),
		.en      (merge_en),
		.lane_res(wk_q),
		.enc_res (enc_q),
		.nonce   (nonce_q),
		.acc     (acc)
	);

	// ---------------- control registers and message state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aerm_pkg::S_IDLE;
			tgt_q       <= aerm_pkg::TGT_MASTER;
			cnt_q       <= '0;
			rnd_q       <= '0;
			ctr_q       <= '0;
			act_q       <= aerm_pkg::ACT_ABSORB;
			out_valid_q <= 1'b0;
			key_q       <= '0;
			for (int i = 0; i < NC; i++) chain_q[i] <= '0;
			for (int i = 0; i < aerm_pkg::NUM_MIX; i++) mix_q[i] <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d == state_q && !cfg_we) ? cnt_q + 5'd1 : 5'd0;
			rnd_q   <= (enc_st && !enc_done && state_d == state_q && !cfg_we) ?
			           rnd_q + 4'd1 : 4'd0;
			if (in_acc) act_q <= action;
			if (hold_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				tgt_q <= aerm_pkg::TGT_MASTER;
				ctr_q <= '0;
				if (cfg_index == aerm_pkg::CFG_KEY_LO) begin
					key_q[63:0] <= cfg_data;
				end else begin
					key_q[127:64] <= cfg_data;
				end
			end else if (state_q == aerm_pkg::S_DENC && enc_done) begin
				ctr_q <= ctr_q + 5'd1;
				if (ctr_q == 5'(aerm_pkg::CTR_NONCE)) tgt_q <= aerm_pkg::TGT_NONCE;
				if (ctr_q == 5'(aerm_pkg::CTR_TAG)) tgt_q <= aerm_pkg::TGT_TAG;
			end
			if (absorb_en) begin
				for (int i = 1; i < NC; i++) chain_q[i] <= lane_o[i-1];
				chain_q[0] <= chain_q[0] ^ chain_q[NC-1] ^ m2;
				mix_q[2] <= mix_q[1];
				mix_q[1] <= mix_q[0];
				mix_q[0] <= mix_q[3] ^ m1;
				mix_q[3] <= m2;
			end else if ((state_q == aerm_pkg::S_ABS && act_q == aerm_pkg::ACT_RESTART) ||
			             (kexp_last && tgt_q == aerm_pkg::TGT_TAG && !cfg_we)) begin
				for (int i = 0; i < NC; i++) chain_q[i] <= icv_q[i];
				for (int i = 0; i < aerm_pkg::NUM_MIX; i++) mix_q[i] <= '0;
			end
		end
	end

	// ---------------- derived stores and working registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_q   <= pad_blk;
			nonce_q <= {nonce_hi, nonce_lo};
		end
		if (enc_st) begin
			enc_q <= (rnd_q == 4'd0) ? (enc_src ^ enc_key) : lane_o[0];
		end
		if (hold_load) tag_q <= enc_q;

		// key expansion register
		if (cfg_we) begin
			kx_q <= (cfg_index == aerm_pkg::CFG_KEY_LO) ? {key_q[127:64], cfg_data}
			                                            : {cfg_data, key_q[63:0]};
		end else if (state_q == aerm_pkg::S_KEXP) begin
			kx_q <= aerm_pkg::key_step(kx_q, aerm_pkg::rcon(cnt_q[3:0] + 4'd1));
		end else if (state_q == aerm_pkg::S_DENC && enc_done) begin
			kx_q <= lane_o[0];
		end

		// round key rings: shift in during expansion, rotate once per round in use
		if ((state_q == aerm_pkg::S_KEXP && tgt_q == aerm_pkg::TGT_MASTER) ||
		    state_q == aerm_pkg::S_DENC) begin
			for (int i = 0; i < aerm_pkg::NUM_RK - 1; i++) mk_q[i] <= mk_q[i+1];
			mk_q[aerm_pkg::NUM_RK-1] <= (state_q == aerm_pkg::S_KEXP) ? kx_q : mk_q[0];
		end
		if ((state_q == aerm_pkg::S_KEXP && tgt_q == aerm_pkg::TGT_NONCE) ||
		    state_q == aerm_pkg::S_NENC) begin
			for (int i = 0; i < aerm_pkg::NUM_RK - 1; i++) nk_q[i] <= nk_q[i+1];
			nk_q[aerm_pkg::NUM_RK-1] <= (state_q == aerm_pkg::S_KEXP) ? kx_q : nk_q[0];
		end
		if ((state_q == aerm_pkg::S_KEXP && tgt_q == aerm_pkg::TGT_TAG) ||
		    state_q == aerm_pkg::S_TENC) begin
			for (int i = 0; i < aerm_pkg::NUM_RK - 1; i++) tk_q[i] <= tk_q[i+1];
			tk_q[aerm_pkg::NUM_RK-1] <= (state_q == aerm_pkg::S_KEXP) ? kx_q : tk_q[0];
		end

		// derived chain values and subkeys in counter order
		if (state_q == aerm_pkg::S_DENC && enc_done && ctr_q < 5'(aerm_pkg::NUM_ICV)) begin
			for (int i = 0; i < aerm_pkg::NUM_ICV - 1; i++) icv_q[i] <= icv_q[i+1];
			icv_q[aerm_pkg::NUM_ICV-1] <= lane_o[0];
		end
		if ((state_q == aerm_pkg::S_DENC && enc_done &&
		     ctr_q >= 5'(aerm_pkg::NUM_ICV) && ctr_q < 5'(aerm_pkg::CTR_NONCE)) ||
		    state_q == aerm_pkg::S_MOD) begin
			for (int i = 0; i < aerm_pkg::NUM_SUBKEY - 1; i++) fsk_q[i] <= fsk_q[i+1];
			fsk_q[aerm_pkg::NUM_SUBKEY-1] <= (state_q == aerm_pkg::S_MOD) ? fsk_q[0]
			                                                              : lane_o[0];
		end

		// lane i works through subkeys i..i+9 as the ring turns
		if (state_q == aerm_pkg::S_MOD && cnt_q < 5'(aerm_pkg::MOD_ROUNDS)) begin
			for (int i = 0; i < NC; i++) wk_q[i] <= lane_o[i];
		end
	end

	assign out_valid = out_valid_q;
	assign tag_lo    = tag_q[63:0];
	assign tag_hi    = tag_q[127:64];

`ifndef SYNTH
	a_rnd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= 4'(aerm_pkg::LAST_ROUND))
		else $error("round counter past last round");

	a_mod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == aerm_pkg::S_MOD |-> cnt_q <= 5'(aerm_pkg::MOD_LAST))
		else $error("subkey ring count overrun");

	a_tag_to_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aerm_pkg::S_TENC && enc_done && !cfg_we) |=> state_q == aerm_pkg::S_HOLD)
		else $error("tag encryption did not hand over to output stage");

	a_cfg_kexp: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == aerm_pkg::S_KEXP && tgt_q == aerm_pkg::TGT_MASTER &&
		            cnt_q == 5'd0))
		else $error("key write did not start master key expansion");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aerm_pkg::S_KEXP || state_q == aerm_pkg::S_DENC) |-> !in_ready)
		else $error("request taken during key derivation");
`endif

endmodule

// ===== test/aerm_checker.sv =====
// aerm_checker: watches the request, tag and key-write ports of the AES round MAC engine,
// predicts every tag from its own AES model and compares; depends on aerm_pkg
module aerm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] msg_word0,
	input  logic [63:0] msg_word1,
	input  logic [63:0] msg_word2,
	input  logic [63:0] msg_word3,
	input  logic [63:0] msg_word4,
	input  logic [63:0] msg_word5,
	input  logic [63:0] msg_word6,
	input  logic [63:0] msg_word7,
	input  logic [5:0]  byte_count,
	input  logic [63:0] nonce_lo,
	input  logic [63:0] nonce_hi,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] tag_lo,
	input  logic [63:0] tag_hi,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] sb [256];
	logic [63:0] key_lo_m, key_hi_m;
	logic [127:0] chain_m [9];
	logic [127:0] mixw_m [4];
	logic [127:0] icv_m [9];
	logic [127:0] fsk_m [18];
	logic [127:0] nrk_m [11];
	logic [127:0] trk_m [11];
	logic [127:0] mrk_m [11];
	logic [127:0] tag_queue [$];

	initial begin
		logic [7:0] p, q;
		p = 8'd1;
		q = 8'd1;
		do begin
			p = p ^ (p << 1) ^ (p[7] ? 8'h1b : 8'h00);
			q = q ^ (q << 1);
			q = q ^ (q << 2);
			q = q ^ (q << 4);
			q = q ^ (q[7] ? 8'h09 : 8'h00);
			sb[p] = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
				^ {q[3:0], q[7:4]} ^ 8'h63;
		end while (p != 8'd1);
		sb[0] = 8'h63;
	end

	function automatic logic [7:0] gmul2(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] subst_rows(logic [127:0] x);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(4*c+r) +: 8] = sb[x[8*(4*((c+r)%4)+r) +: 8]];
		return t;
	endfunction

	function automatic logic [127:0] col_mix(logic [127:0] x);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, s;
		for (int c = 0; c < 4; c++) begin
			a0 = x[32*c +: 8];
			a1 = x[32*c+8 +: 8];
			a2 = x[32*c+16 +: 8];
			a3 = x[32*c+24 +: 8];
			s = a0 ^ a1 ^ a2 ^ a3;
			t[32*c +: 8]    = a0 ^ s ^ gmul2(a0 ^ a1);
			t[32*c+8 +: 8]  = a1 ^ s ^ gmul2(a1 ^ a2);
			t[32*c+16 +: 8] = a2 ^ s ^ gmul2(a2 ^ a3);
			t[32*c+24 +: 8] = a3 ^ s ^ gmul2(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [127:0] one_round(logic [127:0] v, logic [127:0] k);
		return col_mix(subst_rows(v)) ^ k;
	endfunction

	function automatic void key_sched(input logic [127:0] key, output logic [127:0] rk [11]);
		logic [7:0] w [176];
		logic [7:0] t [4];
		logic [7:0] t0;
		logic [7:0] rc [11];
		rc = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
		for (int k = 0; k < 16; k++) w[k] = key[8*k +: 8];
		for (int i = 4; i < 44; i++) begin
			for (int j = 0; j < 4; j++) t[j] = w[4*(i-1)+j];
			if (i % 4 == 0) begin
				t0 = t[0];
				t[0] = sb[t[1]] ^ rc[i/4];
				t[1] = sb[t[2]];
				t[2] = sb[t[3]];
				t[3] = sb[t0];
			end
			for (int j = 0; j < 4; j++) w[4*i+j] = w[4*(i-4)+j] ^ t[j];
		end
		for (int i = 0; i < 11; i++)
			for (int k = 0; k < 16; k++) rk[i][8*k +: 8] = w[16*i+k];
	endfunction

	function automatic logic [127:0] aes128(logic [127:0] rk [11], logic [127:0] x);
		x = x ^ rk[0];
		for (int r = 1; r < 10; r++) x = one_round(x, rk[r]);
		return subst_rows(x) ^ rk[10];
	endfunction

	// ten rounds with the key added up front and no closing key
	function automatic logic [127:0] compress_word(int base, logic [127:0] x);
		for (int r = 0; r < 10; r++) x = col_mix(subst_rows(x ^ fsk_m[base+r]));
		return x;
	endfunction

	function automatic void new_message();
		for (int i = 0; i < 9; i++) chain_m[i] = icv_m[i];
		for (int i = 0; i < 4; i++) mixw_m[i] = '0;
	endfunction

	function automatic void derive_keys();
		logic [127:0] t;
		key_sched({key_hi_m, key_lo_m}, mrk_m);
		for (int i = 0; i < 9; i++) icv_m[i] = aes128(mrk_m, 128'(i));
		for (int i = 0; i < 18; i++) fsk_m[i] = aes128(mrk_m, 128'(9 + i));
		t = aes128(mrk_m, 128'(27));
		key_sched(t, nrk_m);
		t = aes128(mrk_m, 128'(28));
		key_sched(t, trk_m);
		new_message();
	endfunction

	function automatic void absorb_block(logic [127:0] m0, logic [127:0] m1,
		logic [127:0] m2, logic [127:0] m3);
		logic [127:0] t, r12;
		t = chain_m[8];
		r12 = mixw_m[1] ^ mixw_m[2];
		chain_m[8] = one_round(chain_m[7], m3);
		chain_m[7] = one_round(chain_m[6], m1);
		chain_m[6] = one_round(chain_m[5], m1);
		chain_m[5] = one_round(chain_m[4], m0);
		chain_m[4] = one_round(chain_m[3], m0);
		chain_m[3] = one_round(chain_m[2], r12);
		chain_m[2] = one_round(chain_m[1], m3);
		chain_m[1] = one_round(chain_m[0], m3);
		chain_m[0] = chain_m[0] ^ t ^ m2;
		mixw_m[2] = mixw_m[1];
		mixw_m[1] = mixw_m[0];
		mixw_m[0] = mixw_m[3] ^ m1;
		mixw_m[3] = m2;
	endfunction

	function automatic void take_request();
		logic [511:0] blk;
		logic [127:0] nonce, acc;
		int n;
		if (action == aerm_pkg::ACT_RESTART) begin
			new_message();
			return;
		end
		if (action != aerm_pkg::ACT_ABSORB && action != aerm_pkg::ACT_FINAL) return;
		blk = {msg_word7, msg_word6, msg_word5, msg_word4,
			msg_word3, msg_word2, msg_word1, msg_word0};
		if (action == aerm_pkg::ACT_FINAL) begin
			n = byte_count;
			blk[8*n +: 8] = 8'h01;
			for (int i = n + 1; i < 64; i++) blk[8*i +: 8] = 8'h00;
		end
		absorb_block(blk[127:0], blk[255:128], blk[383:256], blk[511:384]);
		if (action == aerm_pkg::ACT_ABSORB) return;
		for (int i = 0; i < 4; i++) absorb_block('0, '0, '0, '0);
		nonce = {nonce_hi, nonce_lo};
		acc = aes128(nrk_m, nonce) ^ nonce;
		for (int i = 0; i < 9; i++) acc = acc ^ compress_word(i, chain_m[i]);
		tag_queue = {tag_queue, aes128(trk_m, acc)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			key_lo_m = '0;
			key_hi_m = '0;
			for (int i = 0; i < 9; i++) begin
				chain_m[i] = '0;
				icv_m[i] = '0;
			end
			for (int i = 0; i < 4; i++) mixw_m[i] = '0;
			for (int i = 0; i < 18; i++) fsk_m[i] = '0;
			for (int i = 0; i < 11; i++) begin
				nrk_m[i] = '0;
				trk_m[i] = '0;
				mrk_m[i] = '0;
			end
			tag_queue.delete();
			fails = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (tag_queue.size() == 0) begin
					$display("%0t: unexpected tag %h_%h", $time, tag_hi, tag_lo);
					fails = fails + 1;
				end else begin
					want = tag_queue.pop_front();
					if (want[63:0] !== tag_lo) begin
						$display("%0t: tag_lo expected %h actual %h", $time, want[63:0], tag_lo);
						fails = fails + 1;
					end
					if (want[127:64] !== tag_hi) begin
						$display("%0t: tag_hi expected %h actual %h", $time, want[127:64],
							tag_hi);
						fails = fails + 1;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == aerm_pkg::CFG_KEY_LO) key_lo_m = cfg_data;
				else key_hi_m = cfg_data;
				derive_keys();
			end
			if (in_valid && in_ready) take_request();
		end
		pending = tag_queue.size();
	end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for the AES round MAC engine
// depends on aerm_pkg, aes_round_mac_engine_unit and aerm_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [63:0] msg_word [8];
	logic [5:0]  byte_count;
	logic [63:0] nonce_lo;
	logic [63:0] nonce_hi;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] tag_lo;
	logic [63:0] tag_hi;
	int          fails;
	int          pending;

	int send_idle;
	int recv_idle;
	int req_count;
	int taken_in;
	int quiet;
	bit hold_start;

	aes_round_mac_engine_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.msg_word0(msg_word[0]), .msg_word1(msg_word[1]), .msg_word2(msg_word[2]),
		.msg_word3(msg_word[3]), .msg_word4(msg_word[4]), .msg_word5(msg_word[5]),
		.msg_word6(msg_word[6]), .msg_word7(msg_word[7]),
		.byte_count(byte_count), .nonce_lo(nonce_lo), .nonce_hi(nonce_hi),
		.out_valid(out_valid), .out_ready(out_ready), .tag_lo(tag_lo), .tag_hi(tag_hi)
	);

	aerm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action),
		.msg_word0(msg_word[0]), .msg_word1(msg_word[1]), .msg_word2(msg_word[2]),
		.msg_word3(msg_word[3]), .msg_word4(msg_word[4]), .msg_word5(msg_word[5]),
		.msg_word6(msg_word[6]), .msg_word7(msg_word[7]),
		.byte_count(byte_count), .nonce_lo(nonce_lo), .nonce_hi(nonce_hi),
		.out_valid(out_valid), .out_ready(out_ready), .tag_lo(tag_lo), .tag_hi(tag_hi),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_in <= 0;
			quiet <= 0;
		end else begin
			if (in_valid && in_ready) taken_in <= taken_in + 1;
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// one request; called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(logic [1:0] act, logic [5:0] bc, bit rand_msg, logic [63:0] fill);
		int seen;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		for (int j = 0; j < 8; j++) msg_word[j] <= rand_msg ? rand_word() : fill;
		byte_count <= bc;
		nonce_lo <= rand_msg ? rand_word() : fill;
		nonce_hi <= rand_msg ? rand_word() : fill;
		seen = taken_in;
		do @(negedge clk); while (taken_in == seen);
		req_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (80) @(negedge clk);
	endtask

	// each write re-derives the whole context, so let derivation finish after it
	task automatic write_key(logic idx, logic [63:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (400) @(negedge clk);
	endtask

	task automatic random_message();
		int n;
		if ($urandom_range(9) != 0) send_req(aerm_pkg::ACT_RESTART, 6'($urandom), 1, '0);
		else if ($urandom_range(1)) send_req(ACT_UNUSED, 6'($urandom), 1, '0);
		n = $urandom_range(4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) send_req(ACT_UNUSED, 6'($urandom), 1, '0);
			send_req(aerm_pkg::ACT_ABSORB, 6'($urandom), 1, '0);
		end
		send_req(aerm_pkg::ACT_FINAL, 6'($urandom_range(63)), 1, '0);
	endtask

	initial begin
		int goal;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aerm_pkg::CFG_KEY_LO;
		cfg_data = '0;
		in_valid = 1'b0;
		action = aerm_pkg::ACT_ABSORB;
		for (int j = 0; j < 8; j++) msg_word[j] = '0;
		byte_count = '0;
		nonce_lo = '0;
		nonce_hi = '0;
		send_idle = 0;
		recv_idle = 0;
		req_count = 0;
		hold_start = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: all-zero key first, no request before it
		write_key(aerm_pkg::CFG_KEY_LO, '0);
		write_key(aerm_pkg::CFG_KEY_HI, '0);
		send_req(aerm_pkg::ACT_RESTART, '0, 0, '0);
		send_req(aerm_pkg::ACT_FINAL, 6'd0, 0, '0);
		send_req(aerm_pkg::ACT_RESTART, '0, 0, '0);
		send_req(aerm_pkg::ACT_ABSORB, '0, 0, '0);
		send_req(aerm_pkg::ACT_ABSORB, '1, 0, '1);
		send_req(aerm_pkg::ACT_FINAL, 6'd63, 0, '1);
		// finalize again without a restart
		send_req(aerm_pkg::ACT_FINAL, 6'd31, 1, '0);
		send_req(ACT_UNUSED, '1, 0, '1);
		send_req(aerm_pkg::ACT_RESTART, '0, 1, '0);
		send_req(aerm_pkg::ACT_ABSORB, '0, 1, '0);
		send_req(ACT_UNUSED, '0, 1, '0);
		send_req(aerm_pkg::ACT_FINAL, 6'd1, 1, '0);
		write_key(aerm_pkg::CFG_KEY_LO, '1);
		write_key(aerm_pkg::CFG_KEY_HI, '1);
		send_req(aerm_pkg::ACT_RESTART, '0, 0, '0);
		send_req(aerm_pkg::ACT_FINAL, 6'd0, 0, '1);
		send_req(aerm_pkg::ACT_RESTART, '0, 0, '0);
		send_req(aerm_pkg::ACT_ABSORB, '0, 1, '0);
		send_req(aerm_pkg::ACT_FINAL, 6'd62, 1, '0);

		for (int seg = 0; seg < 8; seg++) begin
			if (seg == 5) begin
				write_key(aerm_pkg::CFG_KEY_LO, '1);
				write_key(aerm_pkg::CFG_KEY_HI, '0);
			end else begin
				write_key(aerm_pkg::CFG_KEY_LO, {$urandom, $urandom});
				write_key(aerm_pkg::CFG_KEY_HI, {$urandom, $urandom});
			end
			case (seg % 4)
				0: begin send_idle = 0; recv_idle = 0; end
				1: begin send_idle = 48; recv_idle = 0; end
				2: begin send_idle = 0; recv_idle = 48; end
				default: begin send_idle = 30; recv_idle = 30; end
			endcase
			if (seg == 2) hold_start = 1'b1;
			goal = 20 + (seg + 1) * 650 / 8;
			while (req_count < goal) random_message();
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (100) @(negedge clk);
		if (fails == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
